>>> rtl/gbi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the gravity body integrator.
// No dependencies; imported by every module of the block.
package gbi_pkg;

   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 136;

   localparam logic [1:0] OP_ACCUMULATE = 2'd0;
   localparam logic [1:0] OP_ADVANCE    = 2'd1;
   localparam logic [1:0] OP_LOAD       = 2'd2;

   localparam logic [1:0] CSR_GRAVITY = 2'd0;
   localparam logic [1:0] CSR_STEP    = 2'd1;
   localparam logic [1:0] CSR_SCALE   = 2'd2;

   localparam logic [31:0] GRAVITY_RESET = 32'd65536;
   localparam logic [15:0] STEP_RESET    = 16'd256;
   localparam logic [15:0] SCALE_RESET   = 16'd65535;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_CAPTURE,
      CMD_LOAD,
      CMD_DIFF,
      CMD_MUL_SQX,
      CMD_MUL_SQY,
      CMD_MUL_GM,
      CMD_GM_SAVE,
      CMD_START_A,
      CMD_SAVE_A,
      CMD_MUL_AL,
      CMD_MUL_AH,
      CMD_START_C,
      CMD_MUL_CL,
      CMD_MUL_CH,
      CMD_PULL,
      CMD_MUL_SS,
      CMD_SAVE_SS,
      CMD_MUL_V,
      CMD_MOVE,
      CMD_OUT
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
      logic         axis;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       d2_zero;
      logic       div_busy;
      logic       sqrt_busy;
      logic       out_free;
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_LOAD,
      S_DIFF,
      S_SQX,
      S_SQY,
      S_GM,
      S_GMSAVE,
      S_STARTA,
      S_WAITA,
      S_SAVEA,
      S_AL,
      S_AH,
      S_STARTC,
      S_WAITC,
      S_CL,
      S_CH,
      S_PULL,
      S_SS,
      S_SSAVE,
      S_V,
      S_MOVE,
      S_OUT
   } state_type;

endpackage

>>> rtl/gravity_body_integrator.sv
`timescale 1ns / 1ps
// Gravity body integrator: one body's Q16.16 position and velocity, updated by
// accumulate, advance and load items. Depends on gbi_pkg, gbi_controller, gbi_datapath.
//
// One item is worked at a time and gives one result item. A load copies the item into the
// body, an advance moves each axis by its velocity, an unused op leaves the body as it is;
// a full accumulate runs a bit-serial division for the acceleration (square root runs
// beside it) and one more division per axis for the direction, all on one shared divider
// and one 32x32 multiplier. A new item is taken once the previous result is in the output
// register, while that result waits to be taken.
module gravity_body_integrator
   import gbi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // partner_x, partner_y, partner_mass, load_vel_x, load_vel_y
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pos_x, pos_y, vel_x_out, vel_y_out, coincident, saturated, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   gbi_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gbi_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_save_after_units: assert property (@(posedge clock) disable iff (reset)
      cmd.code == CMD_SAVE_A |-> !status.div_busy && !status.sqrt_busy)
      else $error("acceleration taken while divider or root busy");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted back to back");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[128] && rsp_tdata[129]))
      else $error("coincident and saturated both set");

endmodule

>>> rtl/gbi_divider.sv
`timescale 1ns / 1ps
// Restoring divider, 128-bit by 64-bit, one quotient bit per cycle, saturating at 2^64-1.
// Depends on gbi_pkg.
module gbi_divider
   import gbi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] num,
   input  logic [63:0]  den,
   output logic         busy,
   output logic         ovf,
   output logic [63:0]  quo
);

   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] low_ff, low_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] q_ff, q_in;
   logic        ovf_ff, ovf_in;
   logic [64:0] shifted;
   logic [64:0] diff;

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      shifted = {rem_ff, low_ff[63]};
      diff    = shifted - {1'b0, den_ff};
      if (start) begin
         rem_in = num[127:64];
         low_in = num[63:0];
         den_in = den;
         q_in   = '0;
         ovf_in = (num[127:64] >= den);
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         low_in = {low_ff[62:0], 1'b0};
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff[63:0];
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign busy = (cnt_ff != 7'd0);
   assign ovf  = ovf_ff;
   assign quo  = ovf_ff ? {64{1'b1}} : q_ff;

endmodule

>>> rtl/gbi_sqrt.sv
`timescale 1ns / 1ps
// Integer square root of a 64-bit value, one root bit per cycle.
// Depends on gbi_pkg.
module gbi_sqrt
   import gbi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        busy,
   output logic [31:0] root
);

   logic [5:0]  cnt_ff, cnt_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [63:0] val_ff, val_in;
   logic [35:0] shifted;
   logic [35:0] trial;
   logic [35:0] diff;

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      val_in  = val_ff;
      shifted = {rem_ff, val_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = shifted - trial;
      if (start) begin
         rem_in  = '0;
         root_in = '0;
         val_in  = value;
         cnt_in  = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         val_in = {val_ff[61:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = diff[33:0];
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = shifted[33:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      val_ff  <= val_in;
   end

   assign busy = (cnt_ff != 6'd0);
   assign root = root_ff;

endmodule

>>> rtl/gbi_datapath.sv
`timescale 1ns / 1ps
// Datapath: body state, settings, shared multiplier, divider, square root, result register.
// Depends on gbi_pkg, gbi_divider and gbi_sqrt.
module gbi_datapath
   import gbi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [1:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic signed [42:0] MAX32 = 43'sd2147483647;
   localparam logic signed [42:0] MIN32 = -43'sd2147483648;

   function automatic logic [32:0] sat32(input logic signed [42:0] v);
      logic [32:0] r;
      if (v > MAX32) begin
         r = {1'b1, MAX32[31:0]};
      end else if (v < MIN32) begin
         r = {1'b1, MIN32[31:0]};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   logic [31:0]        g_ff, step_ff, scale_ff;
   logic [1:0]         op_ff;
   logic signed [31:0] px_ff, py_ff, lvx_ff, lvy_ff;
   logic [31:0]        mass_ff;
   logic signed [31:0] bx_ff, by_ff, bvx_ff, bvy_ff;
   logic [31:0]        adx_ff, ady_ff;
   logic               negx_ff, negy_ff;
   logic [63:0]        prod_ff, d2_ff, gm_ff, a_ff, acc_ff;
   logic [31:0]        ss_ff;
   logic               coin_ff, sat_ff;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [31:0]        mul_a, mul_b;
   logic               mul_en;
   logic [31:0]        ad_sel;
   logic               neg_sel;
   logic signed [31:0] vel_sel, pos_sel;
   logic [31:0]        vel_mag;
   logic signed [32:0] dxw, dyw;
   logic [32:0]        dxc, dyc;
   logic [95:0]        wide_sum;
   logic [87:0]        pull_m;
   logic [33:0]        pull_c;
   logic signed [42:0] pull_sum, move_sum;
   logic [32:0]        pull_res, move_res;
   logic               div_start, div_busy, div_ovf;
   logic [127:0]       div_num;
   logic [63:0]        div_den, div_quo;
   logic               sqrt_busy;
   logic [31:0]        sqrt_root;
   logic               out_free;

   gbi_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .ovf   (div_ovf),
      .quo   (div_quo)
   );

   gbi_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.code == CMD_START_A),
      .value (d2_ff),
      .busy  (sqrt_busy),
      .root  (sqrt_root)
   );

   always_comb begin
      ad_sel   = cmd.axis ? ady_ff : adx_ff;
      neg_sel  = cmd.axis ? negy_ff : negx_ff;
      vel_sel  = cmd.axis ? bvy_ff : bvx_ff;
      pos_sel  = cmd.axis ? by_ff : bx_ff;
      vel_mag  = vel_sel[31] ? (~vel_sel + 32'd1) : vel_sel;
      dxw      = 33'(px_ff) - 33'(bx_ff);
      dyw      = 33'(py_ff) - 33'(by_ff);
      dxc      = sat32(43'(dxw));
      dyc      = sat32(43'(dyw));
      wide_sum = {32'd0, acc_ff} + {prod_ff, 32'd0};
      pull_m   = wide_sum[95:8];
      pull_c   = (pull_m > (88'd1 << 33)) ? (34'd1 << 33) : pull_m[33:0];
      pull_sum = neg_sel ? (43'(vel_sel) - $signed({9'd0, pull_c}))
                         : (43'(vel_sel) + $signed({9'd0, pull_c}));
      pull_res = sat32(pull_sum);
      move_sum = vel_sel[31] ? (43'(pos_sel) - $signed({3'd0, prod_ff[63:24]}))
                             : (43'(pos_sel) + $signed({3'd0, prod_ff[63:24]}));
      move_res = sat32(move_sum);
      div_start = (cmd.code == CMD_START_A) || (cmd.code == CMD_START_C);
      if (cmd.code == CMD_START_A) begin
         div_num = {32'd0, gm_ff, 32'd0};
         div_den = d2_ff;
      end else begin
         div_num = {32'd0, wide_sum};
         div_den = {32'd0, sqrt_root};
      end
      mul_en = 1'b1;
      case (cmd.code)
         CMD_MUL_SQX: begin mul_a = adx_ff;           mul_b = adx_ff;           end
         CMD_MUL_SQY: begin mul_a = ady_ff;           mul_b = ady_ff;           end
         CMD_MUL_GM:  begin mul_a = g_ff;             mul_b = mass_ff;          end
         CMD_MUL_AL:  begin mul_a = a_ff[31:0];       mul_b = ad_sel;           end
         CMD_MUL_AH:  begin mul_a = a_ff[63:32];      mul_b = ad_sel;           end
         CMD_MUL_CL:  begin mul_a = div_quo[31:0];    mul_b = step_ff;          end
         CMD_MUL_CH:  begin mul_a = div_quo[63:32];   mul_b = step_ff;          end
         CMD_MUL_SS:  begin mul_a = scale_ff;         mul_b = step_ff;          end
         CMD_MUL_V:   begin mul_a = vel_mag;          mul_b = ss_ff;            end
         default: begin
            mul_a  = '0;
            mul_b  = '0;
            mul_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_ff     <= GRAVITY_RESET;
         step_ff  <= {16'd0, STEP_RESET};
         scale_ff <= {16'd0, SCALE_RESET};
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GRAVITY: g_ff     <= csr_data;
            CSR_STEP:    step_ff  <= {16'd0, csr_data[15:0]};
            CSR_SCALE:   scale_ff <= {16'd0, csr_data[15:0]};
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      case (cmd.code)
         CMD_CAPTURE: begin
            op_ff   <= req_tuser;
            px_ff   <= req_tdata[31:0];
            py_ff   <= req_tdata[63:32];
            mass_ff <= req_tdata[95:64];
            lvx_ff  <= req_tdata[127:96];
            lvy_ff  <= req_tdata[159:128];
         end
         CMD_DIFF: begin
            negx_ff <= dxc[31];
            negy_ff <= dyc[31];
            adx_ff  <= dxc[31] ? (~dxc[31:0] + 32'd1) : dxc[31:0];
            ady_ff  <= dyc[31] ? (~dyc[31:0] + 32'd1) : dyc[31:0];
         end
         CMD_MUL_SQY: d2_ff <= prod_ff;
         CMD_MUL_GM:  d2_ff <= d2_ff + prod_ff;
         CMD_GM_SAVE: gm_ff <= prod_ff;
         CMD_SAVE_A:  a_ff  <= div_quo;
         CMD_MUL_AH:  acc_ff <= prod_ff;
         CMD_MUL_CH:  acc_ff <= prod_ff;
         CMD_SAVE_SS: ss_ff <= prod_ff[31:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bx_ff   <= '0;
         by_ff   <= '0;
         bvx_ff  <= '0;
         bvy_ff  <= '0;
         coin_ff <= 1'b0;
         sat_ff  <= 1'b0;
      end else begin
         case (cmd.code)
            CMD_CAPTURE: begin
               coin_ff <= 1'b0;
               sat_ff  <= 1'b0;
            end
            CMD_LOAD: begin
               bx_ff  <= px_ff;
               by_ff  <= py_ff;
               bvx_ff <= lvx_ff;
               bvy_ff <= lvy_ff;
            end
            CMD_DIFF: sat_ff <= dxc[32] | dyc[32];
            CMD_GM_SAVE: begin
               if (d2_ff == 64'd0) begin
                  coin_ff <= 1'b1;
                  sat_ff  <= 1'b0;
               end
            end
            CMD_SAVE_A: begin
               if (div_ovf) begin
                  sat_ff <= 1'b1;
               end
            end
            CMD_PULL: begin
               if (cmd.axis) begin
                  bvy_ff <= pull_res[31:0];
               end else begin
                  bvx_ff <= pull_res[31:0];
               end
               if (pull_res[32]) begin
                  sat_ff <= 1'b1;
               end
            end
            CMD_MOVE: begin
               if (cmd.axis) begin
                  by_ff <= move_res[31:0];
               end else begin
                  bx_ff <= move_res[31:0];
               end
               if (move_res[32]) begin
                  sat_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.code == CMD_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.code == CMD_OUT) begin
         rsp_data_ff <= {6'd0, sat_ff, coin_ff, bvy_ff, bvx_ff, by_ff, bx_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.op        = op_ff;
   assign status.d2_zero   = (d2_ff == 64'd0);
   assign status.div_busy  = div_busy;
   assign status.sqrt_busy = sqrt_busy;
   assign status.out_free  = out_free;

endmodule

>>> rtl/gbi_controller.sv
`timescale 1ns / 1ps
// Sequencer: walks each operation through the datapath by commands.
// Depends on gbi_pkg.
module gbi_controller
   import gbi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      req_tready = 1'b0;
      cmd.code   = CMD_NOP;
      cmd.axis   = axis_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.code = CMD_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            axis_in = 1'b0;
            case (status.op)
               OP_ACCUMULATE: state_in = S_DIFF;
               OP_ADVANCE:    state_in = S_SS;
               OP_LOAD:       state_in = S_LOAD;
               default:       state_in = S_OUT;
            endcase
         end
         S_LOAD: begin
            cmd.code = CMD_LOAD;
            state_in = S_OUT;
         end
         S_DIFF: begin
            cmd.code = CMD_DIFF;
            state_in = S_SQX;
         end
         S_SQX: begin
            cmd.code = CMD_MUL_SQX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.code = CMD_MUL_SQY;
            state_in = S_GM;
         end
         S_GM: begin
            cmd.code = CMD_MUL_GM;
            state_in = S_GMSAVE;
         end
         S_GMSAVE: begin
            cmd.code = CMD_GM_SAVE;
            state_in = status.d2_zero ? S_OUT : S_STARTA;
         end
         S_STARTA: begin
            cmd.code = CMD_START_A;
            state_in = S_WAITA;
         end
         S_WAITA: begin
            if (!status.div_busy && !status.sqrt_busy) begin
               state_in = S_SAVEA;
            end
         end
         S_SAVEA: begin
            cmd.code = CMD_SAVE_A;
            state_in = S_AL;
         end
         S_AL: begin
            cmd.code = CMD_MUL_AL;
            state_in = S_AH;
         end
         S_AH: begin
            cmd.code = CMD_MUL_AH;
            state_in = S_STARTC;
         end
         S_STARTC: begin
            cmd.code = CMD_START_C;
            state_in = S_WAITC;
         end
         S_WAITC: begin
            if (!status.div_busy) begin
               state_in = S_CL;
            end
         end
         S_CL: begin
            cmd.code = CMD_MUL_CL;
            state_in = S_CH;
         end
         S_CH: begin
            cmd.code = CMD_MUL_CH;
            state_in = S_PULL;
         end
         S_PULL: begin
            cmd.code = CMD_PULL;
            if (axis_ff) begin
               state_in = S_OUT;
            end else begin
               axis_in  = 1'b1;
               state_in = S_AL;
            end
         end
         S_SS: begin
            cmd.code = CMD_MUL_SS;
            state_in = S_SSAVE;
         end
         S_SSAVE: begin
            cmd.code = CMD_SAVE_SS;
            state_in = S_V;
         end
         S_V: begin
            cmd.code = CMD_MUL_V;
            state_in = S_MOVE;
         end
         S_MOVE: begin
            cmd.code = CMD_MOVE;
            if (axis_ff) begin
               state_in = S_OUT;
            end else begin
               axis_in  = 1'b1;
               state_in = S_V;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.code = CMD_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

>>> sim/gravity_body_integrator_test.sv
`timescale 1ns / 1ps
// Self-checking bench for gravity_body_integrator: a directed table, then random
// load/accumulate/advance/unused items under several register settings. Depends on gbi_pkg.
module gravity_body_integrator_test
   import gbi_pkg::*;
();

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] vel_x;
      logic [31:0] vel_y;
      logic        coin;
      logic        sat;
   } body_state_type;

   typedef struct {
      logic [1:0]     op;
      logic [31:0]    px, py, mass, vx, vy;
      bit             known;
      body_state_type want;
   } dir_row_type;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [1:0]            csr_index = '0;
   logic [31:0]           csr_data = '0;

   body_state_type expected_states[$];
   int             errors = 0;
   int             results_seen = 0;
   bit             steady = 0;

   // predictor copy of the body and registers
   logic signed [31:0] body_x, body_y, body_vx, body_vy;
   logic [31:0]        g_reg;
   logic [15:0]        step_reg, scale_reg;
   bit                 clamp_hit;

   gravity_body_integrator DUT (.*);

   always #1 clock = ~clock;

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) begin
         clamp_hit = 1;
         return 32'h7fffffff;
      end
      if (v < -64'sd2147483648) begin
         clamp_hit = 1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] root_floor(logic [63:0] v);
      logic [127:0] r;
      logic [127:0] c;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         c = r | (128'd1 << i);
         if (c * c <= {64'd0, v}) r = c;
      end
      return r[31:0];
   endfunction

   function automatic logic [31:0] apply_pull(logic signed [31:0] v, logic [63:0] comp,
                                              bit neg);
      logic [127:0] p;
      logic [127:0] m;
      p = {64'd0, comp} * {112'd0, step_reg};
      m = p >> 8;
      if (m > (128'd1 << 33)) m = 128'd1 << 33;
      return clamp32(neg ? longint'(v) - longint'(m[63:0]) : longint'(v) + longint'(m[63:0]));
   endfunction

   function automatic logic [31:0] apply_move(logic signed [31:0] pos,
                                              logic signed [31:0] vel);
      longint mag;
      logic [63:0] m;
      mag = vel < 0 ? -longint'(vel) : longint'(vel);
      m = (64'(mag) * (64'(scale_reg) * 64'(step_reg))) >> 24;
      return clamp32(vel < 0 ? longint'(pos) - longint'(m) : longint'(pos) + longint'(m));
   endfunction

   function automatic body_state_type integrate(logic [1:0] op, logic [31:0] px,
                                                logic [31:0] py, logic [31:0] mass,
                                                logic [31:0] vx, logic [31:0] vy);
      body_state_type res;
      longint dx, dy;
      logic [63:0] adx, ady, d2, gm, accel, r;
      logic [127:0] num, q;
      bit coin;
      clamp_hit = 0;
      coin = 0;
      case (op)
         OP_ACCUMULATE: begin
            dx = longint'($signed(clamp32(longint'($signed(px)) - longint'(body_x))));
            dy = longint'($signed(clamp32(longint'($signed(py)) - longint'(body_y))));
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            d2 = adx * adx + ady * ady;
            if (d2 == 0) begin
               coin = 1;
               clamp_hit = 0;
            end else begin
               gm = 64'(g_reg) * 64'(mass);
               num = {32'd0, gm, 32'd0};
               if ((gm >> 32) >= d2) clamp_hit = 1;
               q = num / {64'd0, d2};
               accel = q > 128'hffffffffffffffff ? 64'hffffffffffffffff : q[63:0];
               r = 64'(root_floor(d2));
               q = ({64'd0, accel} * {64'd0, adx}) / {64'd0, r};
               body_vx = apply_pull(body_vx,
                                    q > 128'hffffffffffffffff ? '1 : q[63:0], dx < 0);
               q = ({64'd0, accel} * {64'd0, ady}) / {64'd0, r};
               body_vy = apply_pull(body_vy,
                                    q > 128'hffffffffffffffff ? '1 : q[63:0], dy < 0);
            end
         end
         OP_ADVANCE: begin
            body_x = apply_move(body_x, body_vx);
            body_y = apply_move(body_y, body_vy);
         end
         OP_LOAD: begin
            body_x = px;
            body_y = py;
            body_vx = vx;
            body_vy = vy;
         end
         default: ;
      endcase
      res.pos_x = body_x;
      res.pos_y = body_y;
      res.vel_x = body_vx;
      res.vel_y = body_vy;
      res.coin = coin;
      res.sat = clamp_hit;
      return res;
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("result %0d: %s is %h, expected %h", results_seen, field, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      body_state_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_states.size() == 0) begin
            $display("result %0d: no item pending", results_seen);
            errors++;
         end else begin
            want = expected_states.pop_front();
            if (rsp_tdata[31:0] !== want.pos_x) report("pos_x", rsp_tdata[31:0], want.pos_x);
            if (rsp_tdata[63:32] !== want.pos_y) report("pos_y", rsp_tdata[63:32], want.pos_y);
            if (rsp_tdata[95:64] !== want.vel_x) report("vel_x", rsp_tdata[95:64], want.vel_x);
            if (rsp_tdata[127:96] !== want.vel_y)
               report("vel_y", rsp_tdata[127:96], want.vel_y);
            if (rsp_tdata[128] !== want.coin) report("coincident", rsp_tdata[128], want.coin);
            if (rsp_tdata[129] !== want.sat) report("saturated", rsp_tdata[129], want.sat);
         end
         results_seen++;
      end
   end

   // receiver: random stalls, one long hold-off
   initial begin
      int hold;
      bit long_done;
      hold = 0;
      long_done = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 0;
         end else if (!long_done && results_seen >= 60) begin
            long_done = 1;
            hold = 600;
            rsp_tready <= 0;
         end else if (!steady && $urandom_range(0, 99) < 25) begin
            hold = $urandom_range(0, 9) < 8 ? $urandom_range(0, 3) : $urandom_range(20, 80);
            rsp_tready <= 0;
         end else
            rsp_tready <= 1;
      end
   end

   task automatic send_item(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                            logic [31:0] mass, logic [31:0] vx, logic [31:0] vy,
                            bit known, body_state_type want);
      int gap;
      body_state_type pred;
      gap = 0;
      if (!steady) begin
         gap = $urandom_range(0, 99);
         gap = gap < 60 ? 0 : gap < 90 ? $urandom_range(1, 3) : $urandom_range(10, 60);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {vy, vx, mass, py, px};
      do @(posedge clock); while (!req_tready);
      pred = integrate(op, px, py, mass, vx, vy);
      expected_states.push_back(known ? want : pred);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      while (expected_states.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GRAVITY: g_reg = value;
         CSR_STEP:    step_reg = value[15:0];
         CSR_SCALE:   scale_reg = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] near(logic signed [31:0] base);
      int span;
      span = $urandom_range(0, 31);
      return base + ($signed($urandom) >>> span);
   endfunction

   task automatic random_items(int count);
      logic [1:0] op;
      logic [31:0] px, py, mass;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         op = pick < 10 ? OP_LOAD : pick < 65 ? OP_ACCUMULATE :
              pick < 95 ? OP_ADVANCE : OP_UNUSED;
         px = $urandom;
         py = $urandom;
         if (op == OP_ACCUMULATE && $urandom_range(0, 9) < 7) begin
            px = near(body_x);
            py = near(body_y);
            if ($urandom_range(0, 39) == 0) begin
               px = body_x;
               py = body_y;
            end
         end
         if (op == OP_LOAD && $urandom_range(0, 1)) begin
            px = $signed($urandom) >>> $urandom_range(0, 31);
            py = $signed($urandom) >>> $urandom_range(0, 31);
         end
         mass = $urandom >> $urandom_range(0, 31);
         if ((n % 100) == 50) begin
            steady = !steady;
         end
         if (n == count / 2 && count > 100) drain();
         send_item(op, px, py, mass, $signed($urandom) >>> $urandom_range(0, 31),
                   $signed($urandom) >>> $urandom_range(0, 31), 0, '0);
      end
      steady = 0;
   endtask

   dir_row_type directed[15];

   initial begin
      directed = '{
         '{OP_UNUSED, 32'h12345678, 32'h9abcdef0, 32'hffffffff, 32'h0f0f0f0f, 32'hf0f0f0f0,
           1, '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
         '{OP_ACCUMULATE, 32'd0, 32'd0, 32'hffffffff, 32'd0, 32'd0,
           1, '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0}},
         '{OP_LOAD, 32'h00010000, 32'hfffe0000, 32'd5, 32'h7fffffff, 32'h80000000,
           1, '{32'h00010000, 32'hfffe0000, 32'h7fffffff, 32'h80000000, 1'b0, 1'b0}},
         '{OP_ADVANCE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 0, '0},
         '{OP_LOAD, 32'h7fffffff, 32'h80000000, 32'd0, 32'd0, 32'd0,
           1, '{32'h7fffffff, 32'h80000000, 32'd0, 32'd0, 1'b0, 1'b0}},
         '{OP_ACCUMULATE, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'd0, 32'd0, 0, '0},
         '{OP_ACCUMULATE, 32'h7ffffff0, 32'h80000010, 32'd0, 32'd0, 32'd0, 0, '0},
         '{OP_ACCUMULATE, 32'h7ffffffe, 32'h80000001, 32'hffffffff, 32'd0, 32'd0, 0, '0},
         '{OP_LOAD, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
           1, '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
         '{OP_ACCUMULATE, 32'h00010000, 32'd0, 32'd1, 32'd0, 32'd0, 0, '0},
         '{OP_ADVANCE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 0, '0},
         '{OP_UNUSED, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 0, '0},
         '{OP_ACCUMULATE, 32'hfff00000, 32'hffe00000, 32'd1000, 32'd0, 32'd0, 0, '0},
         '{OP_LOAD, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
           1, '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, 1'b0}},
         '{OP_ACCUMULATE, 32'hffffffff, 32'hffffffff, 32'd7, 32'd0, 32'd0,
           1, '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1, 1'b0}}
      };
      body_x = 0;
      body_y = 0;
      body_vx = 0;
      body_vy = 0;
      g_reg = GRAVITY_RESET;
      step_reg = STEP_RESET;
      scale_reg = SCALE_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (directed[i])
         send_item(directed[i].op, directed[i].px, directed[i].py, directed[i].mass,
                   directed[i].vx, directed[i].vy, directed[i].known, directed[i].want);
      random_items(250);
      drain();

      write_reg(CSR_GRAVITY, 32'hffffffff);
      write_reg(CSR_STEP, 32'h0000ffff);
      write_reg(CSR_SCALE, 32'h0000ffff);
      random_items(250);
      drain();

      write_reg(CSR_GRAVITY, 32'd0);
      write_reg(CSR_STEP, 32'd0);
      write_reg(CSR_SCALE, 32'd0);
      random_items(100);
      drain();

      write_reg(CSR_GRAVITY, $urandom);
      write_reg(CSR_STEP, $urandom_range(0, 65535));
      write_reg(CSR_SCALE, $urandom_range(0, 65535));
      random_items(300);
      drain();

      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("gravity_body_integrator: match");
      else
         $display("gravity_body_integrator: mismatch");
      $finish;
   end

   initial begin
      #8000000;
      $display("gravity_body_integrator: mismatch");
      $finish;
   end

endmodule

>>> files.f
rtl/gbi_pkg.sv
rtl/gbi_divider.sv
rtl/gbi_sqrt.sv
rtl/gbi_datapath.sv
rtl/gbi_controller.sv
rtl/gravity_body_integrator.sv
sim/gravity_body_integrator_test.sv
